// File: hdl/htd_pkg.sv
// Shared types, codes and defaults of the Huffman tree decoder.
package htd_pkg;

	localparam int MAX_NODES_DEF    = 512;
	localparam int SYMBOL_WIDTH_DEF = 8;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_DECODE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] node_index;
		logic [8:0] parent_index;
		logic [7:0] leaf_symbol;
		logic [7:0] data_byte;
		logic       final_byte;
		logic [3:0] used_bits;
	} item_t;

	typedef struct packed {
		logic [7:0] decoded_symbol;
		logic       decode_error;
		logic       last_of_run;
	} result_t;

	// Node table port controls.
	typedef struct packed {
		logic rd_en;
		logic lk_we;
		logic sym_we;
	} mem_ctl_t;

	// Result buffer controls.
	typedef struct packed {
		logic push;
		logic flush;
	} ob_ctl_t;

endpackage

// File: hdl/htd_node_store.sv
// Node table: child link memory and leaf symbol memory with registered reads.
module htd_node_store #(
	parameter int MAX_NODES    = htd_pkg::MAX_NODES_DEF,
	parameter int SYMBOL_WIDTH = htd_pkg::SYMBOL_WIDTH_DEF,
	localparam int IDX_W = $clog2(MAX_NODES),
	localparam int LW    = 2 + 2 * IDX_W
) (
	input  logic                    clk,
	input  htd_pkg::mem_ctl_t       ctl,
	input  logic [IDX_W-1:0]        rd_addr,
	input  logic [IDX_W-1:0]        lk_waddr,
	input  logic [LW-1:0]           lk_wdata,
	input  logic [IDX_W-1:0]        sym_waddr,
	input  logic [SYMBOL_WIDTH-1:0] sym_wdata,
	output logic [LW-1:0]           lk_rdata,
	output logic [SYMBOL_WIDTH-1:0] sym_rdata
);
	import htd_pkg::*;

	logic [LW-1:0]           lk_mem  [MAX_NODES];
	logic [SYMBOL_WIDTH-1:0] sym_mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (ctl.lk_we) begin
			lk_mem[lk_waddr] <= lk_wdata;
		end
		if (ctl.rd_en) begin
			lk_rdata <= lk_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sym_we) begin
			sym_mem[sym_waddr] <= sym_wdata;
		end
		if (ctl.rd_en) begin
			sym_rdata <= sym_mem[rd_addr];
		end
	end

endmodule

// File: hdl/htd_out_buf.sv
// Result buffer: a hold stage that learns the last-of-run flag, then the output register.
module htd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  htd_pkg::ob_ctl_t  ctl,
	input  logic [7:0]        push_symbol,
	input  logic              push_error,
	output logic              blocked,
	output logic              res_valid,
	input  logic              res_ready,
	output htd_pkg::result_t  res
);
	import htd_pkg::*;

	logic    hold_v_q;
	result_t hold_q;
	logic    out_v_q;
	result_t out_q;
	logic    out_free;
	logic    move;

	// A held result only goes out once the next one arrives or the byte ends.
	assign out_free = !out_v_q || res_ready;
	assign blocked  = hold_v_q && !out_free;
	assign move     = hold_v_q && (ctl.push || ctl.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.push) begin
				hold_v_q <= 1'b1;
			end else if (ctl.flush) begin
				hold_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			hold_q.decoded_symbol <= push_symbol;
			hold_q.decode_error   <= push_error;
			hold_q.last_of_run    <= 1'b0;
		end
		if (move) begin
			out_q.decoded_symbol <= hold_q.decoded_symbol;
			out_q.decode_error   <= hold_q.decode_error;
			out_q.last_of_run    <= ctl.flush;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

// File: hdl/huffman_tree_decoder_top.sv
// Huffman tree decoder top level: walk sequencer around the node table and result buffer.
//
// The decoder takes one item at a time and holds item_ready low while it works on it.
// A load item writes its leaf symbol as it is accepted and, when it links the node to a
// parent, goes on through S_LINK, since the parent's link word is read and written back
// through the node table. A decode item fetches the current walk node, then takes one
// step per walked bit (eight for a full byte), settles the last step and closes the
// run; a missing child met right after a leaf costs an extra step. The walk is
// serialized by the node table's single read port: each bit's step depends on
// the node read for the bit before. Results wait in a hold stage until the next result
// or the end of the byte tells whether they are the last of the run, then in an output
// register, so a stalled result side only stops the walk when both are full. A clear
// item, and every reset, starts a clearing pass that zeroes one link word per cycle,
// until all MAX_NODES link words are clear; no item is accepted during the pass.
module huffman_tree_decoder_top #(
	parameter int MAX_NODES    = htd_pkg::MAX_NODES_DEF,
	parameter int SYMBOL_WIDTH = htd_pkg::SYMBOL_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  htd_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_ready,
	output htd_pkg::result_t res
);
	import htd_pkg::*;

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int LW    = 2 + 2 * IDX_W;
	// Link word layout: left present, right present, left child, right child.
	localparam int LP    = LW - 1;
	localparam int RP    = LW - 2;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_LINK  = 5'b00100,
		S_WALK  = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	function automatic logic [IDX_W-1:0] idx_of(input logic [8:0] v);
		logic [IDX_W+8:0] w;
		w = {{IDX_W{1'b0}}, v};
		return w[IDX_W-1:0];
	endfunction

	function automatic logic idx_ok(input logic [8:0] v);
		logic [IDX_W+8:0] w;
		w = {{IDX_W{1'b0}}, v};
		return w < (IDX_W + 9)'(MAX_NODES);
	endfunction

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q, clr_d;
	logic [IDX_W-1:0] walk_q, walk_d;
	logic [IDX_W-1:0] chld_q, chld_d;
	logic [IDX_W-1:0] par_q, par_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [LW-1:0]    cur_q, cur_d;
	logic [LW-1:0]    root_q, root_d;
	logic             fetch_q, fetch_d;
	logic             step_q, step_d;
	logic             fin_q, fin_d;
	logic [7:0]       bits_q, bits_d;
	logic [3:0]       left_q, left_d;

	mem_ctl_t          mctl;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  lk_waddr;
	logic [LW-1:0]     lk_wdata;
	logic [IDX_W-1:0]  sym_waddr;
	logic [SYMBOL_WIDTH-1:0] sym_wdata;
	logic [LW-1:0]     lk_rdata;
	logic [SYMBOL_WIDTH-1:0] sym_rdata;

	ob_ctl_t    octl;
	logic [7:0] push_symbol;
	logic       push_error;
	logic       ob_blocked;

	logic [LW-1:0]    eff_cur;
	logic [LW-1:0]    new_link;
	logic             leaf_c;
	logic             have_bit;
	logic             bit_one;
	logic             ok;
	logic [IDX_W-1:0] child;
	logic             push;
	logic [3:0]       nbits;
	logic [SYMBOL_WIDTH+7:0] sym_wide;
	logic [SYMBOL_WIDTH+7:0] leaf_wide;

	assign item_ready = (state_q == S_IDLE);

	// A step that lands on a node with no children has reached a leaf.
	assign leaf_c  = step_q && !lk_rdata[LP] && !lk_rdata[RP];
	assign eff_cur = leaf_c ? root_q : ((step_q || fetch_q) ? lk_rdata : cur_q);
	assign have_bit = (left_q != 4'd0);
	assign bit_one  = bits_q[7];
	assign ok       = bit_one ? eff_cur[LP] : eff_cur[RP];
	assign child    = bit_one ? eff_cur[2*IDX_W-1:IDX_W] : eff_cur[IDX_W-1:0];
	// Missing child right after a leaf waits for a step of its own so only one result leaves per cycle.
	assign push     = leaf_c || (have_bit && !ok);

	assign nbits     = (item.used_bits > BYTE_BITS) ? BYTE_BITS : item.used_bits;
	assign sym_wide  = {8'd0, sym_rdata};
	assign leaf_wide = {{SYMBOL_WIDTH{1'b0}}, item.leaf_symbol};

	assign push_symbol = leaf_c ? sym_wide[7:0] : 8'd0;
	assign push_error  = !leaf_c;
	assign sym_waddr   = idx_of(item.node_index);
	assign sym_wdata   = leaf_wide[SYMBOL_WIDTH-1:0];

	// The first child linked to a parent goes left, any later one goes right.
	always_comb begin
		new_link = lk_rdata;
		if (lk_rdata[LP]) begin
			new_link[RP]          = 1'b1;
			new_link[IDX_W-1:0]   = idx_q;
		end else begin
			new_link[LP]                = 1'b1;
			new_link[2*IDX_W-1:IDX_W]   = idx_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		walk_d   = walk_q;
		chld_d   = chld_q;
		par_d    = par_q;
		idx_d    = idx_q;
		cur_d    = cur_q;
		root_d   = root_q;
		fetch_d  = fetch_q;
		step_d   = step_q;
		fin_d    = fin_q;
		bits_d   = bits_q;
		left_d   = left_q;
		mctl     = '0;
		octl     = '0;
		rd_addr  = walk_q;
		lk_waddr = clr_q;
		lk_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mctl.lk_we = 1'b1;
				if (clr_q == IDX_W'(0)) begin
					root_d = '0;
				end
				if (clr_q == IDX_W'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + IDX_W'(1);
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					case (item.mode)
						MODE_LOAD: begin
							mctl.sym_we = idx_ok(item.node_index);
							par_d = idx_of(item.parent_index);
							idx_d = idx_of(item.node_index);
							rd_addr = idx_of(item.parent_index);
							if (idx_ok(item.node_index) && idx_ok(item.parent_index)
									&& (item.node_index != 9'd0)) begin
								mctl.rd_en = 1'b1;
								state_d    = S_LINK;
							end
						end
						MODE_DECODE: begin
							mctl.rd_en = 1'b1;
							fetch_d = 1'b1;
							step_d  = 1'b0;
							bits_d  = item.data_byte;
							fin_d   = item.final_byte;
							left_d  = item.final_byte ? nbits : BYTE_BITS;
							state_d = S_WALK;
						end
						MODE_CLEAR: begin
							walk_d  = '0;
							clr_d   = '0;
							state_d = S_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			S_LINK: begin
				mctl.lk_we = 1'b1;
				lk_waddr   = par_q;
				lk_wdata   = new_link;
				if (par_q == IDX_W'(0)) begin
					root_d = new_link;
				end
				state_d = S_IDLE;
			end
			S_WALK: begin
				rd_addr = child;
				if (!(push && ob_blocked)) begin
					octl.push = push;
					cur_d     = eff_cur;
					fetch_d   = 1'b0;
					step_d    = 1'b0;
					if (step_q) begin
						walk_d = leaf_c ? '0 : chld_q;
					end
					if (!have_bit) begin
						state_d = S_FLUSH;
					end else if (ok) begin
						mctl.rd_en = 1'b1;
						step_d = 1'b1;
						chld_d = child;
						bits_d = {bits_q[6:0], 1'b0};
						left_d = left_q - 4'd1;
					end else begin
						walk_d = '0;
						cur_d  = root_q;
						if (!leaf_c) begin
							bits_d = {bits_q[6:0], 1'b0};
							left_d = left_q - 4'd1;
						end
					end
				end
			end
			S_FLUSH: begin
				if (!ob_blocked) begin
					octl.flush = 1'b1;
					if (fin_q) begin
						walk_d = '0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			walk_q  <= '0;
			root_q  <= '0;
			fetch_q <= 1'b0;
			step_q  <= 1'b0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			walk_q  <= walk_d;
			root_q  <= root_d;
			fetch_q <= fetch_d;
			step_q  <= step_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		chld_q <= chld_d;
		par_q  <= par_d;
		idx_q  <= idx_d;
		cur_q  <= cur_d;
		fin_q  <= fin_d;
		bits_q <= bits_d;
	end

	htd_node_store #(
		.MAX_NODES    (MAX_NODES),
		.SYMBOL_WIDTH (SYMBOL_WIDTH)
	) u_store (
		.clk       (clk),
		.ctl       (mctl),
		.rd_addr   (rd_addr),
		.lk_waddr  (lk_waddr),
		.lk_wdata  (lk_wdata),
		.sym_waddr (sym_waddr),
		.sym_wdata (sym_wdata),
		.lk_rdata  (lk_rdata),
		.sym_rdata (sym_rdata)
	);

	htd_out_buf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (octl),
		.push_symbol (push_symbol),
		.push_error  (push_error),
		.blocked     (ob_blocked),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule

// File: hdl/htd_checker.sv
// Port-level checks of the Huffman tree decoder and their binding to the top level.
module htd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input htd_pkg::item_t   item,
	input logic             res_valid,
	input logic             res_ready,
	input htd_pkg::result_t res
);
	import htd_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_err_sym: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.decode_error |-> res.decoded_symbol == 8'd0)
		else $error("error result carries a symbol");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.mode == MODE_DECODE |=> !item_ready)
		else $error("ready right after a decode item");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.mode == MODE_CLEAR |=> !item_ready ##1 !item_ready)
		else $error("clearing pass ended too early");

endmodule

bind huffman_tree_decoder_top htd_checker u_checker (.*);
